// ===== rtl/core/apc_pkg.sv =====
// ----------------------------------------------------------------------------
// apc_pkg
// Widths, constants and the front-to-back item type of the arrowhead point
// calculator.
// ----------------------------------------------------------------------------
`default_nettype none

package apc_pkg;

  localparam int FRAC_BITS     = 8;
  localparam int CORDIC_STAGES = 16;

  localparam int CW        = 24;
  localparam int DW        = CW + 1;
  localparam int LH_EXTRA  = 7;
  localparam int QW        = 2 * DW;
  localparam int LW        = (QW + 2 * LH_EXTRA + 1) / 2;
  localparam int SQW       = 2 * LW;
  localparam int TW        = DW + CORDIC_STAGES + 1;
  localparam int NW        = TW + LH_EXTRA + 1;
  localparam int UW        = CORDIC_STAGES + 1;
  localparam int SZW       = 16;
  localparam int SSW       = SZW + FRAC_BITS;
  localparam int PW        = SSW + UW;
  localparam int OW        = PW - CORDIC_STAGES + 1;
  localparam int RW        = OW + 2;
  localparam int SIZE_SHIFT = FRAC_BITS + LH_EXTRA + 1;
  localparam int LANES     = 4;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam longint unsigned COS30_Q32 = 64'd3719550787;
  localparam logic [CORDIC_STAGES:0] COS_C = (CORDIC_STAGES + 1)'(
    (COS30_Q32 + (64'd1 << (31 - CORDIC_STAGES))) >> (32 - CORDIC_STAGES));

  localparam logic [SZW-1:0] SIZE_RESET = SZW'(15);

  localparam logic signed [RW-1:0] OUT_MAX = RW'(8388607);
  localparam logic signed [RW-1:0] OUT_MIN = -RW'(8388608);

  typedef struct packed {
    logic [CW-1:0]            end_x;
    logic [CW-1:0]            end_y;
    logic [LW-1:0]            lh;
    logic [SZW-1:0]           size;
    logic [LANES-1:0][TW-1:0] t;
  } apc_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/arrowhead_point_calc.sv =====
// ----------------------------------------------------------------------------
// arrowhead_point_calc
// Arrowhead barb points at the end of a fixed-point line segment.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents (low bit first)
//  cfg      in   cfg_data: max_arrow_size[15:0]
//  in       in   in_tdata: start_x, start_y, end_x, end_y (24 bit each)
//  out      out  out_tdata: barb1_x, barb1_y, barb2_x, barb2_y (24 bit each)
//
//  One segment per cycle sustained while neither half stalls. Each segment
//  passes through 3 setup stages, 32 square-root stages, the queue, an
//  operand stage, 17 divider stages per lane, a multiply stage and the
//  output register.
//  Synchronous active-low reset clears valids, queue pointers and sets
//  max_arrow_size to 15. The front stalls only when the queue is full;
//  the back stalls when the output beat is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module arrowhead_point_calc (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,    // max_arrow_size[15:0]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,    // start_x, start_y, end_x, end_y
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata    // barb1_x, barb1_y, barb2_x, barb2_y
);

  logic [apc_pkg::SZW-1:0] max_size_r;
  logic                    fifo_full, fifo_empty, push, pop;
  apc_pkg::apc_item_t      push_item, pop_item;
  logic [apc_pkg::LANES-1:0][apc_pkg::CW-1:0] barb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_size_r <= apc_pkg::SIZE_RESET;
    end else if (cfg_valid) begin
      max_size_r <= cfg_data;
    end
  end

  apc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .start_x   (in_tdata[23:0]),
    .start_y   (in_tdata[47:24]),
    .end_x     (in_tdata[71:48]),
    .end_y     (in_tdata[95:72]),
    .cfg_max   (max_size_r),
    .fifo_full (fifo_full),
    .push      (push),
    .push_item (push_item)
  );

  apc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (fifo_full),
    .pop       (pop),
    .empty     (fifo_empty),
    .pop_item  (pop_item)
  );

  apc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fifo_empty (fifo_empty),
    .pop        (pop),
    .item       (pop_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .barb       (barb)
  );

  assign out_tdata = barb;

endmodule

`default_nettype wire

// ===== rtl/core/apc_fifo.sv =====
// ----------------------------------------------------------------------------
// apc_fifo
// Short queue between the front and back halves.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire apc_pkg::apc_item_t push_item,
  output logic                    full,
  input  wire logic               pop,
  output logic                    empty,
  output apc_pkg::apc_item_t      pop_item
);

  apc_pkg::apc_item_t                  mem_r [apc_pkg::FIFO_DEPTH];
  logic [apc_pkg::FIFO_AW-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [apc_pkg::FIFO_AW-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [apc_pkg::FIFO_AW:0]           count_r, count_nxt;

  assign full     = (count_r == (apc_pkg::FIFO_AW + 1)'(apc_pkg::FIFO_DEPTH));
  assign empty    = (count_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (apc_pkg::FIFO_AW + 1)'(push) - (apc_pkg::FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/apc_front.sv =====
// ----------------------------------------------------------------------------
// apc_front
// Segment deltas, squared length, rotated direction numerators, pipelined
// integer square root and head size.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [apc_pkg::CW-1:0] start_x,
  input  wire logic [apc_pkg::CW-1:0] start_y,
  input  wire logic [apc_pkg::CW-1:0] end_x,
  input  wire logic [apc_pkg::CW-1:0] end_y,
  input  wire logic [apc_pkg::SZW-1:0] cfg_max,
  input  wire logic                   fifo_full,
  output logic                        push,
  output apc_pkg::apc_item_t          push_item
);

  localparam int LW  = apc_pkg::LW;
  localparam int SQW = apc_pkg::SQW;
  localparam int TW  = apc_pkg::TW;

  logic en;
  assign en       = !fifo_full;
  assign in_ready = en;

  logic                             v0_r, v1_r, v2_r;
  logic signed [apc_pkg::DW-1:0]    dx0_r, dy0_r, dx1_r, dy1_r;
  logic [apc_pkg::CW-1:0]           ex0_r, ey0_r, ex1_r, ey1_r, ex2_r, ey2_r;
  logic signed [apc_pkg::QW-1:0]    sqx1_r, sqy1_r;
  logic signed [TW-1:0]             dxc1_r, dyc1_r;
  logic [apc_pkg::QW-1:0]           q2_r;
  logic [apc_pkg::LANES-1:0][TW-1:0] t2_r;
  logic signed [TW-1:0]             dxh, dyh;
  logic signed [apc_pkg::QW-1:0]    q_sum;

  logic                             sv_r   [LW];
  logic [SQW-1:0]                   sn_r   [LW];
  logic [SQW-1:0]                   sres_r [LW];
  logic [apc_pkg::LANES-1:0][TW-1:0] st_r  [LW];
  logic [apc_pkg::CW-1:0]           sex_r  [LW];
  logic [apc_pkg::CW-1:0]           sey_r  [LW];
  logic [SQW-1:0]                   sn_nxt   [LW];
  logic [SQW-1:0]                   sres_nxt [LW];

  logic [LW-1:0]                    lh;
  logic [LW-1:0]                    sz_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int k = 0; k < LW; k++) begin
        sv_r[k] <= 1'b0;
      end
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      sv_r[0] <= v2_r;
      for (int k = 1; k < LW; k++) begin
        sv_r[k] <= sv_r[k-1];
      end
    end
  end

  assign dxh   = TW'(dx1_r) <<< (apc_pkg::CORDIC_STAGES - 1);
  assign dyh   = TW'(dy1_r) <<< (apc_pkg::CORDIC_STAGES - 1);
  assign q_sum = sqx1_r + sqy1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx0_r  <= $signed({end_x[apc_pkg::CW-1], end_x}) -
                $signed({start_x[apc_pkg::CW-1], start_x});
      dy0_r  <= $signed({end_y[apc_pkg::CW-1], end_y}) -
                $signed({start_y[apc_pkg::CW-1], start_y});
      ex0_r  <= end_x;
      ey0_r  <= end_y;

      sqx1_r <= dx0_r * dx0_r;
      sqy1_r <= dy0_r * dy0_r;
      dxc1_r <= dx0_r * $signed({1'b0, apc_pkg::COS_C});
      dyc1_r <= dy0_r * $signed({1'b0, apc_pkg::COS_C});
      dx1_r  <= dx0_r;
      dy1_r  <= dy0_r;
      ex1_r  <= ex0_r;
      ey1_r  <= ey0_r;

      q2_r    <= $unsigned(q_sum);
      t2_r[0] <= $unsigned(dxc1_r + dyh);
      t2_r[1] <= $unsigned(dyc1_r - dxh);
      t2_r[2] <= $unsigned(dxc1_r - dyh);
      t2_r[3] <= $unsigned(dyc1_r + dxh);
      ex2_r   <= ex1_r;
      ey2_r   <= ey1_r;
    end
  end

  always_comb begin
    logic [SQW-1:0] cn;
    logic [SQW-1:0] cr;
    logic [SQW-1:0] bt;
    logic [SQW-1:0] tr;
    for (int k = 0; k < LW; k++) begin
      cn = (k == 0) ? SQW'({q2_r, (2 * apc_pkg::LH_EXTRA)'(0)}) : sn_r[(k == 0) ? 0 : k - 1];
      cr = (k == 0) ? '0 : sres_r[(k == 0) ? 0 : k - 1];
      bt = SQW'(1) << (SQW - 2 - 2 * k);
      tr = cr + bt;
      if (cn >= tr) begin
        sn_nxt[k]   = cn - tr;
        sres_nxt[k] = (cr >> 1) + bt;
      end else begin
        sn_nxt[k]   = cn;
        sres_nxt[k] = cr >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LW; k++) begin
        sn_r[k]   <= sn_nxt[k];
        sres_r[k] <= sres_nxt[k];
      end
      st_r[0]  <= t2_r;
      sex_r[0] <= ex2_r;
      sey_r[0] <= ey2_r;
      for (int k = 1; k < LW; k++) begin
        st_r[k]  <= st_r[k-1];
        sex_r[k] <= sex_r[k-1];
        sey_r[k] <= sey_r[k-1];
      end
    end
  end

  assign lh      = sres_r[LW-1][LW-1:0];
  assign sz_full = lh >> apc_pkg::SIZE_SHIFT;

  always_comb begin
    push_item.end_x = sex_r[LW-1];
    push_item.end_y = sey_r[LW-1];
    push_item.lh    = lh;
    push_item.t     = st_r[LW-1];
    if (sz_full > LW'(cfg_max)) begin
      push_item.size = cfg_max;
    end else begin
      push_item.size = sz_full[apc_pkg::SZW-1:0];
    end
  end

  assign push = en && sv_r[LW-1];

endmodule

`default_nettype wire

// ===== rtl/core/apc_div.sv =====
// ----------------------------------------------------------------------------
// apc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_div (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [apc_pkg::NW-1:0] num,
  input  wire logic [apc_pkg::LW-1:0] den,
  output logic      [apc_pkg::UW-1:0] quot
);

  localparam int NW = apc_pkg::NW;
  localparam int UW = apc_pkg::UW;

  logic [NW-1:0]          rem_r [UW];
  logic [UW-1:0]          q_r   [UW];
  logic [apc_pkg::LW-1:0] den_r [UW];
  logic [NW-1:0]          rem_nxt [UW];
  logic [UW-1:0]          q_nxt   [UW];

  always_comb begin
    logic [NW-1:0]          cr;
    logic [UW-1:0]          cq;
    logic [apc_pkg::LW-1:0] cd;
    logic [NW-1:0]          dsh;
    for (int j = 0; j < UW; j++) begin
      cr  = (j == 0) ? num : rem_r[(j == 0) ? 0 : j - 1];
      cq  = (j == 0) ? '0  : q_r[(j == 0) ? 0 : j - 1];
      cd  = (j == 0) ? den : den_r[(j == 0) ? 0 : j - 1];
      dsh = NW'(cd) << (UW - 1 - j);
      if (cr >= dsh) begin
        rem_nxt[j] = cr - dsh;
        q_nxt[j]   = cq | (UW'(1) << (UW - 1 - j));
      end else begin
        rem_nxt[j] = cr;
        q_nxt[j]   = cq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= rem_nxt[0];
      q_r[0]   <= q_nxt[0];
      den_r[0] <= den;
      for (int j = 1; j < UW; j++) begin
        rem_r[j] <= rem_nxt[j];
        q_r[j]   <= q_nxt[j];
        den_r[j] <= den_r[j-1];
      end
    end
  end

  assign quot = q_r[UW-1];

endmodule

`default_nettype wire

// ===== rtl/core/apc_back.sv =====
// ----------------------------------------------------------------------------
// apc_back
// Unit direction by division, offset scaling with rounding, and saturated
// barb coordinates into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module apc_back (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    fifo_empty,
  output logic                         pop,
  input  wire apc_pkg::apc_item_t      item,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [apc_pkg::LANES-1:0][apc_pkg::CW-1:0] barb
);

  localparam int UW    = apc_pkg::UW;
  localparam int LANES = apc_pkg::LANES;
  localparam int TW    = apc_pkg::TW;
  localparam int NW    = apc_pkg::NW;
  localparam int CW    = apc_pkg::CW;
  localparam int RW    = apc_pkg::RW;
  localparam int OW    = apc_pkg::OW;
  localparam int PW    = apc_pkg::PW;

  logic                          out_valid_r;
  logic [LANES-1:0][CW-1:0]      barb_r;

  logic en;
  assign en  = !out_valid_r || out_ready;
  assign pop = en && !fifo_empty;

  logic                          v0_r;
  logic [LANES-1:0][NW-1:0]      num0_r;
  logic [apc_pkg::LW-1:0]        den0_r;
  logic [LANES-1:0]              neg0_r;
  logic [apc_pkg::SZW-1:0]       size0_r;
  logic [LANES-1:0][CW-1:0]      end0_r;

  logic                          dv_r    [UW];
  logic [LANES-1:0]              dneg_r  [UW];
  logic [apc_pkg::SZW-1:0]       dsize_r [UW];
  logic [LANES-1:0][CW-1:0]      dend_r  [UW];

  logic [LANES-1:0][UW-1:0]      quot;

  logic                          mv_r;
  logic [LANES-1:0]              mneg_r;
  logic [LANES-1:0][CW-1:0]      mend_r;
  logic [LANES-1:0][PW-1:0]      prod_r;

  logic [LANES-1:0][TW-1:0]      tmag;
  logic [apc_pkg::SSW-1:0]       ss;
  logic [LANES-1:0][CW-1:0]      barb_nxt;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      tmag[l] = item.t[l][TW-1] ? (~item.t[l] + 1'b1) : item.t[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      mv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < UW; j++) begin
        dv_r[j] <= 1'b0;
      end
    end else if (en) begin
      v0_r    <= pop;
      dv_r[0] <= v0_r;
      for (int j = 1; j < UW; j++) begin
        dv_r[j] <= dv_r[j-1];
      end
      mv_r        <= dv_r[UW-1];
      out_valid_r <= mv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        num0_r[l] <= (NW'(tmag[l]) << apc_pkg::LH_EXTRA) + NW'(item.lh >> 1);
        neg0_r[l] <= item.t[l][TW-1];
      end
      den0_r    <= item.lh;
      size0_r   <= item.size;
      end0_r[0] <= item.end_x;
      end0_r[1] <= item.end_y;
      end0_r[2] <= item.end_x;
      end0_r[3] <= item.end_y;

      dneg_r[0]  <= neg0_r;
      dsize_r[0] <= size0_r;
      dend_r[0]  <= end0_r;
      for (int j = 1; j < UW; j++) begin
        dneg_r[j]  <= dneg_r[j-1];
        dsize_r[j] <= dsize_r[j-1];
        dend_r[j]  <= dend_r[j-1];
      end

      for (int l = 0; l < LANES; l++) begin
        prod_r[l] <= PW'(ss) * PW'(quot[l]);
      end
      mneg_r <= dneg_r[UW-1];
      mend_r <= dend_r[UW-1];

      barb_r <= barb_nxt;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    apc_div u_div (
      .clk  (clk),
      .en   (en),
      .num  (num0_r[l]),
      .den  (den0_r),
      .quot (quot[l])
    );
  end

  assign ss = {dsize_r[UW-1], apc_pkg::FRAC_BITS'(0)};

  always_comb begin
    logic [PW:0]            rsum;
    logic [OW-1:0]          offm;
    logic signed [RW-1:0]   offs;
    logic signed [RW-1:0]   val;
    for (int l = 0; l < LANES; l++) begin
      rsum = (PW + 1)'(prod_r[l]) + ((PW + 1)'(1) << (apc_pkg::CORDIC_STAGES - 1));
      offm = OW'(rsum >> apc_pkg::CORDIC_STAGES);
      offs = mneg_r[l] ? -$signed(RW'(offm)) : $signed(RW'(offm));
      val  = $signed(RW'($signed(mend_r[l]))) - offs;
      if (val > apc_pkg::OUT_MAX) begin
        barb_nxt[l] = CW'(apc_pkg::OUT_MAX);
      end else if (val < apc_pkg::OUT_MIN) begin
        barb_nxt[l] = CW'(apc_pkg::OUT_MIN);
      end else begin
        barb_nxt[l] = val[CW-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign barb      = barb_r;

endmodule

`default_nettype wire
